// ===== src/gha_pkg.sv =====
// ----------------------------------------------------------------------------
// Generational handle allocator package
// Sizes, operation codes, controller states and the scan result type shared
// by the allocator, its scanner and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gha_pkg;

    localparam int SLOTS       = 64;
    localparam int HANDLE_BITS = 32;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int LINK_W      = SLOT_W + 1;
    // Find-first is split in two levels: groups of GRP slots, then NGRP groups.
    localparam int GRP_W       = SLOT_W / 2;
    localparam int GRP         = 1 << GRP_W;
    localparam int NGRP        = SLOTS / GRP;
    // One memory word holds the free-list link above the handle.
    localparam int MEM_W       = LINK_W + HANDLE_BITS;
    // All-ones handle: never issued, reported on failure, starts an iteration.
    localparam logic [HANDLE_BITS-1:0] INVALID_H = '1;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NEXT   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
    } t_scan_res;

endpackage

// ===== src/gha_if.sv =====
// ----------------------------------------------------------------------------
// Generational handle allocator channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gha_req_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      op;
    logic [gha_pkg::HANDLE_BITS-1:0] handle;

    modport source (output valid, output op, output handle, input ready);
    modport sink   (input valid, input op, input handle, output ready);
endinterface

interface gha_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            status;
    logic [gha_pkg::HANDLE_BITS-1:0] result_handle;
    logic [gha_pkg::SLOT_W-1:0]      slot_index;

    modport source (output valid, output status, output result_handle,
                    output slot_index, input ready);
    modport sink   (input valid, input status, input result_handle,
                    input slot_index, output ready);
endinterface

// ===== src/gha_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/gha_scan.sv =====
// ----------------------------------------------------------------------------
// Busy-slot scanner
// Two-level find-first of the lowest busy slot at or above a start index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gha_scan (
    input  logic                       i_clk,
    input  logic                       i_start,
    input  logic [gha_pkg::SLOTS-1:0]  i_busy,
    input  logic [gha_pkg::LINK_W-1:0] i_from,
    output gha_pkg::t_scan_res         o_res
);

    logic [gha_pkg::SLOTS-1:0]  elig;
    logic [gha_pkg::NGRP-1:0]   n_any;
    logic [gha_pkg::SLOT_W-1:0] n_first [gha_pkg::NGRP];
    logic [gha_pkg::NGRP-1:0]   r_any;
    logic [gha_pkg::SLOT_W-1:0] r_first [gha_pkg::NGRP];

    // First level: lowest eligible slot inside each group.
    always_comb begin
        for (int j = 0; j < gha_pkg::SLOTS; j++) begin
            elig[j] = i_busy[j] && (gha_pkg::LINK_W'(j) >= i_from);
        end
        for (int g = 0; g < gha_pkg::NGRP; g++) begin
            n_any[g]   = 1'b0;
            n_first[g] = '0;
            for (int e = gha_pkg::GRP - 1; e >= 0; e--) begin
                if (elig[g * gha_pkg::GRP + e]) begin
                    n_any[g]   = 1'b1;
                    n_first[g] = gha_pkg::SLOT_W'(g * gha_pkg::GRP + e);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_any   <= n_any;
            r_first <= n_first;
        end
    end

    // Second level: lowest group with a hit.
    always_comb begin
        o_res = '0;
        for (int g = gha_pkg::NGRP - 1; g >= 0; g--) begin
            if (r_any[g]) begin
                o_res.found = 1'b1;
                o_res.idx   = r_first[g];
            end
        end
    end

endmodule

// ===== src/generational_handle_allocator.sv =====
// ----------------------------------------------------------------------------
// Generational handle allocator
// Slot pool with generation-tagged handles and a last-in-first-out free list.
// ----------------------------------------------------------------------------
// Each request transaction carries an operation (allocate, free, lookup, next)
// and a handle, and yields exactly one response transaction. A slot's handle
// and free-list link live together in one slot memory with a registered read;
// busy bits and per-slot written bits are flip-flops, so an entry never
// written reads back its reset handle (its own index) and link (index plus
// one), and no clearing pass runs after reset. Allocate, free and lookup
// accept and issue the slot memory read, then check, write back and load the
// response register. Next adds the two-level find-first over the busy bits
// ahead of the memory read. A pending response does not block the next
// request; only the write-back cycle waits for the response register to
// free up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module generational_handle_allocator (
    input  logic   i_clk,
    input  logic   i_rst_n,
    gha_req_if.sink   i_req,
    gha_rsp_if.source o_rsp
);

    // Controller state
    gha_pkg::t_state                r_state, n_state;
    gha_pkg::t_op                   r_op;
    logic [gha_pkg::HANDLE_BITS-1:0] r_h;
    logic [gha_pkg::SLOT_W-1:0]     r_idx, n_idx;
    logic                           r_fail, n_fail;
    logic [gha_pkg::LINK_W-1:0]     r_free_head, n_free_head;
    logic [gha_pkg::SLOTS-1:0]      r_busy, n_busy;
    logic [gha_pkg::SLOTS-1:0]      r_wr, n_wr;

    // Response register
    logic                           r_o_valid;
    logic                           r_o_status, n_o_status;
    logic [gha_pkg::HANDLE_BITS-1:0] r_o_handle, n_o_handle;
    logic [gha_pkg::SLOT_W-1:0]     r_o_idx, n_o_idx;

    // Request decode
    logic                           acc;
    gha_pkg::t_op                   in_op;
    logic [gha_pkg::SLOT_W-1:0]     in_idx;
    logic [gha_pkg::LINK_W-1:0]     scan_from;
    logic                           scan_start;
    gha_pkg::t_scan_res             scan_res;

    // Slot memory
    logic                           mem_re, mem_we;
    logic [gha_pkg::SLOT_W-1:0]     mem_raddr;
    logic [gha_pkg::MEM_W-1:0]      mem_wdata, mem_rdata;
    logic [gha_pkg::HANDLE_BITS-1:0] eff_hdl, next_gen, bump;
    logic [gha_pkg::LINK_W-1:0]     eff_link;
    logic                           hit, out_free, load_out;

    assign i_req.ready = (r_state == gha_pkg::ST_IDLE);
    assign acc         = i_req.valid && i_req.ready;
    assign in_op       = gha_pkg::t_op'(i_req.op);
    assign in_idx      = i_req.handle[gha_pkg::SLOT_W-1:0];
    // Start of iteration is the all-ones handle; otherwise begin past its slot.
    assign scan_from   = (i_req.handle == gha_pkg::INVALID_H) ? '0
                       : ({1'b0, in_idx} + gha_pkg::LINK_W'(1));
    assign scan_start  = acc && (in_op == gha_pkg::OP_NEXT);
    assign out_free    = !r_o_valid || o_rsp.ready;

    gha_scan u_scan (
        .i_clk   (i_clk),
        .i_start (scan_start),
        .i_busy  (r_busy),
        .i_from  (scan_from),
        .o_res   (scan_res)
    );

    gha_ram #(
        .WIDTH (gha_pkg::MEM_W),
        .DEPTH (gha_pkg::SLOTS)
    ) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_idx),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Unwritten entries read as their reset contents.
    assign eff_hdl  = r_wr[r_idx] ? mem_rdata[gha_pkg::HANDLE_BITS-1:0]
                    : gha_pkg::HANDLE_BITS'(r_idx);
    assign eff_link = r_wr[r_idx] ? mem_rdata[gha_pkg::MEM_W-1:gha_pkg::HANDLE_BITS]
                    : ({1'b0, r_idx} + gha_pkg::LINK_W'(1));
    assign hit      = r_busy[r_idx] && (eff_hdl == r_h);

    // Next generation: advance by the slot count, skip the invalid value.
    assign bump     = r_h + gha_pkg::HANDLE_BITS'(gha_pkg::SLOTS);
    assign next_gen = (bump == gha_pkg::INVALID_H)
                    ? (bump + gha_pkg::HANDLE_BITS'(gha_pkg::SLOTS))
                    : bump;
    assign mem_wdata = {r_free_head, next_gen};

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_fail      = r_fail;
        n_free_head = r_free_head;
        n_busy      = r_busy;
        n_wr        = r_wr;
        n_o_status  = r_o_status;
        n_o_handle  = r_o_handle;
        n_o_idx     = r_o_idx;
        mem_re      = 1'b0;
        mem_raddr   = in_idx;
        mem_we      = 1'b0;
        load_out    = 1'b0;

        unique case (r_state)
            gha_pkg::ST_IDLE: begin
                if (acc) begin
                    n_state = gha_pkg::ST_EXEC;
                    unique case (in_op) inside
                        gha_pkg::OP_ALLOC: begin
                            // Head at the slot count means an empty free list.
                            n_fail    = r_free_head[gha_pkg::SLOT_W];
                            n_idx     = r_free_head[gha_pkg::SLOT_W-1:0];
                            mem_raddr = r_free_head[gha_pkg::SLOT_W-1:0];
                            mem_re    = !r_free_head[gha_pkg::SLOT_W];
                        end
                        gha_pkg::OP_FREE, gha_pkg::OP_LOOKUP: begin
                            n_fail = 1'b0;
                            n_idx  = in_idx;
                            mem_re = 1'b1;
                        end
                        gha_pkg::OP_NEXT: begin
                            n_state = gha_pkg::ST_SCAN;
                        end
                        default: begin
                            n_state = gha_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            gha_pkg::ST_SCAN: begin
                // Scanner result is ready; fetch the found slot's handle.
                n_fail    = !scan_res.found;
                n_idx     = scan_res.idx;
                mem_raddr = scan_res.idx;
                mem_re    = scan_res.found;
                n_state   = gha_pkg::ST_EXEC;
            end
            gha_pkg::ST_EXEC: begin
                // Hold here until the response register can take the result.
                if (out_free) begin
                    load_out   = 1'b1;
                    n_state    = gha_pkg::ST_IDLE;
                    n_o_status = 1'b1;
                    n_o_handle = gha_pkg::INVALID_H;
                    n_o_idx    = '0;
                    case (r_op)
                        gha_pkg::OP_ALLOC: begin
                            if (!r_fail) begin
                                n_o_status    = 1'b0;
                                n_o_handle    = eff_hdl;
                                n_o_idx       = r_idx;
                                n_free_head   = eff_link;
                                n_busy[r_idx] = 1'b1;
                            end
                        end
                        gha_pkg::OP_FREE: begin
                            if (hit) begin
                                n_o_status    = 1'b0;
                                n_o_handle    = r_h;
                                n_o_idx       = r_idx;
                                mem_we        = 1'b1;
                                n_wr[r_idx]   = 1'b1;
                                n_busy[r_idx] = 1'b0;
                                n_free_head   = {1'b0, r_idx};
                            end
                        end
                        gha_pkg::OP_LOOKUP: begin
                            if (hit) begin
                                n_o_status = 1'b0;
                                n_o_handle = r_h;
                                n_o_idx    = r_idx;
                            end
                        end
                        default: begin
                            if (!r_fail) begin
                                n_o_status = 1'b0;
                                n_o_handle = eff_hdl;
                                n_o_idx    = r_idx;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = gha_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gha_pkg::ST_IDLE;
            r_free_head <= '0;
            r_busy      <= '0;
            r_wr        <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_busy      <= n_busy;
            r_wr        <= n_wr;
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op <= in_op;
            r_h  <= i_req.handle;
        end
        r_idx      <= n_idx;
        r_fail     <= n_fail;
        r_o_status <= n_o_status;
        r_o_handle <= n_o_handle;
        r_o_idx    <= n_o_idx;
    end

    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.result_handle = r_o_handle;
    assign o_rsp.slot_index    = r_o_idx;

endmodule

// ===== src/gha_checker.sv =====
// ----------------------------------------------------------------------------
// Generational handle allocator checker
// Port-level properties of the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gha_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_rsp_valid,
    input logic                            i_rsp_ready,
    input logic                            i_status,
    input logic [gha_pkg::HANDLE_BITS-1:0] i_result_handle,
    input logic [gha_pkg::SLOT_W-1:0]      i_slot_index
);

    // A stalled response transaction holds.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_status)
            && $stable(i_result_handle) && $stable(i_slot_index)))
        else $error("stalled response changed");

    // Failure reports the invalid handle and slot zero.
    a_fail_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_status) |-> ((&i_result_handle) && (i_slot_index == '0)))
        else $error("failure response malformed");

    // A good handle names its slot in its low bits.
    a_slot_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_status)
            |-> (i_result_handle[gha_pkg::SLOT_W-1:0] == i_slot_index))
        else $error("handle and slot index disagree");

    // A good handle is never the invalid value.
    a_no_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_status) |-> !(&i_result_handle))
        else $error("success with invalid handle");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_status        (o_rsp.status),
    .i_result_handle (o_rsp.result_handle),
    .i_slot_index    (o_rsp.slot_index)
);
